FILE: rtl/core/fpfl_pkg.sv
// Package: widths, codes and request/response types of the free-list slot allocator.
package fpfl_pkg;

  localparam int POOL_SLOTS = 64;
  localparam int SLOT_W     = $clog2(POOL_SLOTS);
  localparam int LINK_W     = $clog2(POOL_SLOTS + 1);

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  localparam logic [1:0] STAT_OK           = 2'd0;
  localparam logic [1:0] STAT_EMPTY        = 2'd1;
  localparam logic [1:0] STAT_ALREADY_FREE = 2'd2;

  typedef enum logic {
    FSM_IDLE,
    FSM_EXEC
  } fsm_state_e;

  typedef struct packed {
    logic       mode;
    logic [5:0] slot_index;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [5:0] granted_slot;
    logic [6:0] allocated_count;
  } rsp_t;

endpackage

FILE: rtl/core/fixed_pool_free_list_allocator.sv
// Top level: LIFO free-list slot allocator over a fixed pool with a link memory.
// An accepted request passes through the execute state into a registered response, which comes
// later while an earlier response is still held at the output.
// A new request is taken only after the previous one leaves the execute state, which gives the
// registered read of the link memory time to return the next free slot after the head.
// Reset: head at slot 0, count 0, every slot marked free; link entries read as i+1
// until first written (per-entry written bits), so no clearing pass is needed.
module fixed_pool_free_list_allocator (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  fpfl_pkg::req_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output fpfl_pkg::rsp_t out_data_o
);
  import fpfl_pkg::*;

  fsm_state_e          state_q, state_d;
  req_t                req_q;
  logic [LINK_W-1:0]   head_q, head_d;
  logic [LINK_W-1:0]   count_q, count_d;
  logic [POOL_SLOTS-1:0] free_mark_q, free_mark_d;
  logic [POOL_SLOTS-1:0] link_written_q, link_written_d;
  logic                out_valid_q;
  rsp_t                out_data_q;

  logic [LINK_W-1:0]   link_mem [POOL_SLOTS];
  logic [LINK_W-1:0]   link_rdata_q;

  logic                in_accept;
  logic                commit;
  logic                link_re;
  logic                link_we;
  logic [SLOT_W-1:0]   head_idx;
  logic [SLOT_W-1:0]   req_idx;
  logic                slot_in_pool;
  rsp_t                rsp;

  assign in_ready_o = (state_q == FSM_IDLE);
  assign in_accept  = in_valid_i && in_ready_o;
  assign head_idx   = head_q[SLOT_W-1:0];
  assign req_idx    = req_q.slot_index[SLOT_W-1:0];
  assign slot_in_pool = (int'(req_q.slot_index) < POOL_SLOTS);

  // Read the head's link on an allocate request
  assign link_re = in_accept && (in_data_i.mode == MODE_ALLOC);

  // Link memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (link_we) begin
      link_mem[req_idx] <= head_q;
    end
    if (link_re) begin
      link_rdata_q <= link_mem[head_idx];
    end
  end

  // Sequence the request and compute the new state
  always_comb begin
    state_d        = state_q;
    head_d         = head_q;
    count_d        = count_q;
    free_mark_d    = free_mark_q;
    link_written_d = link_written_q;
    link_we        = 1'b0;
    commit         = 1'b0;
    rsp            = '0;

    unique case (state_q)
      FSM_IDLE: begin
        if (in_accept) begin
          state_d = FSM_EXEC;
        end
      end
      FSM_EXEC: begin
        if (!out_valid_q || out_ready_i) begin
          commit  = 1'b1;
          state_d = FSM_IDLE;
          if (req_q.mode == MODE_ALLOC) begin
            if (head_q >= LINK_W'(POOL_SLOTS)) begin
              rsp.status = STAT_EMPTY;
            end else begin
              rsp.status       = STAT_OK;
              rsp.granted_slot = 6'(head_idx);
              head_d = link_written_q[head_idx] ? link_rdata_q : head_q + LINK_W'(1);
              free_mark_d[head_idx] = 1'b0;
              if (count_q < LINK_W'(POOL_SLOTS)) begin
                count_d = count_q + LINK_W'(1);
              end
            end
          end else begin
            if (!slot_in_pool || free_mark_q[req_idx]) begin
              rsp.status = STAT_ALREADY_FREE;
            end else begin
              rsp.status = STAT_OK;
              link_we    = 1'b1;
              link_written_d[req_idx] = 1'b1;
              free_mark_d[req_idx]    = 1'b1;
              head_d = LINK_W'(req_idx);
              if (count_q != '0) begin
                count_d = count_q - LINK_W'(1);
              end
            end
          end
          rsp.allocated_count = 7'(count_d);
        end
      end
      default: state_d = FSM_IDLE;
    endcase
  end

  // Hold control state and the allocator registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= FSM_IDLE;
      head_q         <= '0;
      count_q        <= '0;
      free_mark_q    <= '1;
      link_written_q <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      head_q         <= head_d;
      count_q        <= count_d;
      free_mark_q    <= free_mark_d;
      link_written_q <= link_written_d;
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Capture the request and the response payload
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_q <= in_data_i;
    end
    if (commit) begin
      out_data_q <= rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // The allocated count never exceeds the pool size
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= LINK_W'(POOL_SLOTS))
    else $error("allocated count beyond pool size");

  // The list head is a slot or the end-of-list mark
  a_head_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= LINK_W'(POOL_SLOTS))
    else $error("list head out of range");

  // A refused request grants no slot
  a_granted_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status != STAT_OK) |-> (out_data_o.granted_slot == '0))
    else $error("slot granted on failed request");

  // An execute step with room at the output is back in idle with the response valid in the next cycle
  a_exec_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == FSM_EXEC && (!out_valid_q || out_ready_i))
      |=> (state_q == FSM_IDLE && out_valid_q))
    else $error("execute step did not complete");

  // A granted slot leaves the free set
  a_grant_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit && rsp.status == STAT_OK && req_q.mode == MODE_ALLOC)
      |=> !free_mark_q[$past(head_idx)])
    else $error("granted slot still marked free");

endmodule
